// ===== src/wwnr_pkg.sv =====
// ----------------------------------------------------------------------------
// wwnr_pkg: shared types and constants of the whole-word number replacer
// Word sizes, register indexes, the result token carried from the match
// cells to the output queue, and small character helpers.
// ----------------------------------------------------------------------------
package wwnr_pkg;

   // width of a configuration value and its decimal digit count
   localparam int BIN_W      = 32;
   localparam int DEC_DIGITS = 10;

   // default number of digits kept of a configured number
   localparam int MAX_DIGITS_DEFAULT = 10;

   // token queue in front of the output register, power of two
   localparam int RSP_Q_DEPTH = 4;
   localparam int RSP_Q_AW    = $clog2(RSP_Q_DEPTH);

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_NUMBER      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_NUMBER = 1'b1;

   localparam logic [7:0] ASCII_ZERO = 8'h30;

   // what one queued token stands for
   typedef enum logic {
      TOK_LITERAL,
      TOK_REPLACE
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   lit_byte;
      logic         last;
   } tok_type;

   // per-cell control
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

   // decimal converter status
   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [CSR_IDX_W-1:0] index;
   } conv_stat_type;

   // ascii letter or digit
   function automatic logic is_word_byte(input logic [7:0] b);
      return ((b >= 8'h30) && (b <= 8'h39)) ||
             ((b >= 8'h41) && (b <= 8'h5A)) ||
             ((b >= 8'h61) && (b <= 8'h7A));
   endfunction

   // ascii character of a decimal digit
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      return ASCII_ZERO + {4'd0, d};
   endfunction

endpackage

// ===== src/wwnr_intf.sv =====
// ----------------------------------------------------------------------------
// wwnr channel interfaces
// Text input channel, rewritten text output channel and register write
// channel, each a valid/ready handshake moving one word per accept.
// ----------------------------------------------------------------------------
interface wwnr_req_if import wwnr_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface wwnr_rsp_if import wwnr_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface wwnr_csr_if import wwnr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] wr_index;
   logic [BIN_W-1:0]     wr_data;

   modport source (output valid, output wr_index, output wr_data, input ready);
   modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

// ===== src/whole_word_number_replacer.sv =====
// ----------------------------------------------------------------------------
// whole_word_number_replacer: whole-word decimal number find and replace
// Copies a byte stream, replacing each whole-word occurrence of the decimal
// text of one number by the decimal text of another.
// ----------------------------------------------------------------------------
// Usage:
//   req_port carries one text byte per word, with in_last on the final byte
//   of a text. rsp_port returns the rewritten text, out_last on its final
//   byte. csr_port writes search_number (index 0) or replacement_number
//   (index 1); write only while the block is idle.
// Throughput and flow:
//   one input word per cycle while the cell row has room and no flush or
//   conversion holds input off. Bytes that may still start the search text
//   sit in the cell row until decided; a decided byte then passes through
//   the token queue and the output register on its way to rsp_port. A
//   replacement is expanded digit by digit on the output register; the
//   four-entry token queue absorbs bursts. After an in_last word, input
//   stalls until the held bytes are drained, slower as replacements expand
//   or rsp_port stalls. A write is converted to decimal one bit per cycle;
//   csr_port and req_port are held off until the conversion is done.
// Reset:
//   both numbers read as 0, the cell row is empty and a new text begins.
// Stalls:
//   when rsp_port.ready is low, the output register holds its word, the
//   queue fills, and the cell row then stops and backs up into req_port.
// ----------------------------------------------------------------------------
module whole_word_number_replacer import wwnr_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   wwnr_req_if.sink   req_port,
   wwnr_rsp_if.source rsp_port,
   wwnr_csr_if.sink   csr_port
);

   localparam int DEPTH = MAX_DIGITS + 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int LEN_W = $clog2(MAX_DIGITS + 1);

   // configured digit strings
   logic [3:0]       search_dig_ff  [MAX_DIGITS];
   logic [3:0]       replace_dig_ff [MAX_DIGITS];
   logic [LEN_W-1:0] search_len_ff;
   logic [LEN_W-1:0] replace_len_ff;

   // converter
   conv_stat_type    conv_stat;
   logic [3:0]       conv_digits [MAX_DIGITS];
   logic [LEN_W-1:0] conv_length;
   logic             conv_start;

   // cell row
   cell_ctl_type     cell_ctl   [DEPTH];
   logic [7:0]       cell_byte  [DEPTH];
   logic [3:0]       cell_digit [DEPTH];
   logic [DEPTH-1:0] cell_hit;
   logic [DEPTH-1:0] cell_word;
   logic [DEPTH-1:0] held_valid;

   // stream control state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] skip_ff, skip_in;
   logic             drop_ff, drop_in;
   logic [7:0]       prev_ff, prev_in;
   logic             start_ff, start_in;
   logic             last_ff, last_in;

   // decision
   logic             prefix_ok;
   logic             full_match;
   logic             at_len;
   logic             single;
   logic             left_ok;
   logic             op_shift;
   logic             emit;
   logic             skip_set;
   logic             accept_match;
   logic             go;
   logic             shift;
   logic [CNT_W-1:0] cnt_shift;
   logic             req_ready;
   logic             take;
   logic             flush_done;
   tok_type          tok;
   logic             q_full;

   // register writes go through the decimal converter
   assign csr_port.ready = !conv_stat.busy;
   assign conv_start     = csr_port.valid && !conv_stat.busy;

   wwnr_dec_conv #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_conv (
      .clock       (clock),
      .reset       (reset),
      .start       (conv_start),
      .start_index (csr_port.wr_index),
      .start_value (csr_port.wr_data),
      .stat        (conv_stat),
      .digits      (conv_digits),
      .length      (conv_length)
   );

   // digit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_DIGITS; i++) begin
            search_dig_ff[i]  <= 4'd0;
            replace_dig_ff[i] <= 4'd0;
         end
         search_len_ff  <= LEN_W'(1);
         replace_len_ff <= LEN_W'(1);
      end else if (conv_stat.done) begin
         unique case (conv_stat.index)
            CSR_SEARCH_NUMBER: begin
               search_dig_ff <= conv_digits;
               search_len_ff <= conv_length;
            end
            CSR_REPLACEMENT_NUMBER: begin
               replace_dig_ff <= conv_digits;
               replace_len_ff <= conv_length;
            end
         endcase
      end
   end

   // row of held-byte cells, head at cell 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [7:0] nbr;
      if (i + 1 < DEPTH) begin : g_nbr
         assign nbr = cell_byte[i + 1];
      end else begin : g_end
         assign nbr = 8'h00;
      end
      if (i < MAX_DIGITS) begin : g_dig
         assign cell_digit[i] = search_dig_ff[i];
      end else begin : g_nodig
         assign cell_digit[i] = 4'd0;
      end
      assign cell_ctl[i].shift = shift;
      assign cell_ctl[i].load  = take && (CNT_W'(i) == cnt_shift);

      wwnr_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[i]),
         .nbr_byte (nbr),
         .new_byte (req_port.in_byte),
         .digit    (cell_digit[i]),
         .cur_byte (cell_byte[i]),
         .hit      (cell_hit[i]),
         .word     (cell_word[i])
      );
   end

   // match status of the held bytes against the search text
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         held_valid[i] = (CNT_W'(i) < count_ff);
      end
      prefix_ok = 1'b1;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if ((LEN_W'(i) < search_len_ff) && held_valid[i] && !cell_hit[i]) begin
            prefix_ok = 1'b0;
         end
      end
      at_len     = (count_ff == CNT_W'(search_len_ff));
      full_match = prefix_ok && (count_ff >= CNT_W'(search_len_ff));
      single     = (count_ff == CNT_W'(1));
      left_ok    = start_ff || !is_word_byte(prev_ff);
   end

   // one step of the scan per cycle
   always_comb begin
      op_shift     = 1'b0;
      emit         = 1'b0;
      skip_set     = 1'b0;
      accept_match = 1'b0;
      tok.kind     = TOK_LITERAL;
      tok.lit_byte = cell_byte[0];
      tok.last     = last_ff && single;
      if (skip_ff != '0) begin
         // rest of a decided occurrence
         op_shift = 1'b1;
         emit     = !drop_ff;
      end else if (count_ff != '0) begin
         if (full_match) begin
            // decide once the right neighbor or the end of text is known
            if (!at_len || last_ff) begin
               op_shift     = 1'b1;
               emit         = 1'b1;
               skip_set     = 1'b1;
               accept_match = left_ok && (at_len || !cell_word[search_len_ff]);
               if (accept_match) begin
                  tok.kind = TOK_REPLACE;
                  tok.last = last_ff && at_len;
               end
            end
         end else if (!prefix_ok || last_ff) begin
            // head byte cannot start a match
            op_shift = 1'b1;
            emit     = 1'b1;
         end
      end
      go         = !emit || !q_full;
      shift      = op_shift && go;
      cnt_shift  = count_ff - CNT_W'(shift);
      flush_done = last_ff && shift && single;
   end

   // input word acceptance
   assign req_ready      = !last_ff && !conv_stat.busy && (cnt_shift < CNT_W'(DEPTH));
   assign req_port.ready = req_ready;
   assign take           = req_port.valid && req_ready;

   // next stream state
   always_comb begin
      count_in = cnt_shift + CNT_W'(take);
      skip_in  = skip_ff;
      drop_in  = drop_ff;
      prev_in  = prev_ff;
      start_in = start_ff;
      last_in  = last_ff || (take && req_port.in_last);
      if (shift) begin
         prev_in  = cell_byte[0];
         start_in = 1'b0;
         if (skip_set) begin
            skip_in = search_len_ff - LEN_W'(1);
            drop_in = accept_match;
         end else if (skip_ff != '0) begin
            skip_in = skip_ff - LEN_W'(1);
         end
      end
      if (flush_done) begin
         count_in = '0;
         skip_in  = '0;
         prev_in  = 8'h00;
         start_in = 1'b1;
         last_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         skip_ff  <= '0;
         drop_ff  <= 1'b0;
         prev_ff  <= 8'h00;
         start_ff <= 1'b1;
         last_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         skip_ff  <= skip_in;
         drop_ff  <= drop_in;
         prev_ff  <= prev_in;
         start_ff <= start_in;
         last_ff  <= last_in;
      end
   end

   // token queue and output register
   wwnr_out_q #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_out_q (
      .clock      (clock),
      .reset      (reset),
      .push       (emit && shift),
      .push_tok   (tok),
      .full       (q_full),
      .rep_digits (replace_dig_ff),
      .rep_length (replace_len_ff),
      .out_valid  (rsp_port.valid),
      .out_ready  (rsp_port.ready),
      .out_byte   (rsp_port.out_byte),
      .out_last   (rsp_port.out_last)
   );

`ifndef SYNTHESIS
   // bytes still to pass of a decided occurrence are held in the row
   a_skip_held: assert property (@(posedge clock) disable iff (reset)
      (skip_ff != '0) |-> (CNT_W'(skip_ff) <= count_ff))
      else $error("skip count exceeds held bytes");

   // end of a text leaves an empty row and a fresh stream
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      $fell(last_ff) |-> ((count_ff == '0) && start_ff && (skip_ff == '0)))
      else $error("stream state not cleared after flush");

   // the row never holds more than its cells
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      take |=> (count_ff <= CNT_W'(DEPTH)))
      else $error("cell row overflow");
`endif

endmodule

// ===== src/wwnr_cell.sv =====
// ----------------------------------------------------------------------------
// wwnr_cell: one held-byte cell of the match row
// Holds one undecided byte, takes its right neighbor's byte on a shift or
// the incoming byte on a load, and compares against its search digit.
// ----------------------------------------------------------------------------
module wwnr_cell import wwnr_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic [7:0]   nbr_byte,
   input  logic [7:0]   new_byte,
   input  logic [3:0]   digit,
   output logic [7:0]   cur_byte,
   output logic         hit,
   output logic         word
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // load beats shift: the load target is the first free slot after a shift
   always_comb begin
      byte_in = byte_ff;
      if (ctl.load) begin
         byte_in = new_byte;
      end else if (ctl.shift) begin
         byte_in = nbr_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // compare and classify
   assign cur_byte = byte_ff;
   assign hit      = (byte_ff == digit_char(digit));
   assign word     = is_word_byte(byte_ff);

endmodule

// ===== src/wwnr_dec_conv.sv =====
// ----------------------------------------------------------------------------
// wwnr_dec_conv: binary to decimal digit converter
// Shift-and-add-3 conversion of a written register value, one bit per
// cycle, then the leading digits and digit count are presented for a cycle.
// ----------------------------------------------------------------------------
module wwnr_dec_conv import wwnr_pkg::*; #(
   parameter  int MAX_DIGITS = MAX_DIGITS_DEFAULT,
   localparam int LEN_W      = $clog2(MAX_DIGITS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CSR_IDX_W-1:0] start_index,
   input  logic [BIN_W-1:0]     start_value,
   output conv_stat_type        stat,
   output logic [3:0]           digits [MAX_DIGITS],
   output logic [LEN_W-1:0]     length
);

   localparam int STEP_W = $clog2(BIN_W);
   localparam int BCD_W  = 4 * DEC_DIGITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DONE
   } state_type;

   state_type            state_ff;
   logic [BIN_W-1:0]     bin_ff;
   logic [BCD_W-1:0]     bcd_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [CSR_IDX_W-1:0] idx_ff;
   logic [BCD_W-1:0]     bcd_adj;
   logic [3:0]           sig_digits;

   // add 3 to every bcd digit of five or more
   always_comb begin
      for (int k = 0; k < DEC_DIGITS; k++) begin
         bcd_adj[4*k +: 4] = (bcd_ff[4*k +: 4] >= 4'd5) ? (bcd_ff[4*k +: 4] + 4'd3)
                                                         : bcd_ff[4*k +: 4];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  bin_ff   <= start_value;
                  bcd_ff   <= '0;
                  step_ff  <= '0;
                  idx_ff   <= start_index;
                  state_ff <= ST_SHIFT;
               end
            end
            ST_SHIFT: begin
               bcd_ff  <= {bcd_adj[BCD_W-2:0], bin_ff[BIN_W-1]};
               bin_ff  <= {bin_ff[BIN_W-2:0], 1'b0};
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(BIN_W - 1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // count of significant digits, at least one
   always_comb begin
      sig_digits = 4'd1;
      for (int k = 0; k < DEC_DIGITS; k++) begin
         if (bcd_ff[4*k +: 4] != 4'd0) begin
            sig_digits = 4'(k + 1);
         end
      end
   end

   // leading digits, most significant first
   always_comb begin
      int pos;
      for (int j = 0; j < MAX_DIGITS; j++) begin
         pos       = int'(sig_digits) - 1 - j;
         digits[j] = 4'd0;
         if (pos >= 0) begin
            digits[j] = bcd_ff[4*pos +: 4];
         end
      end
      if (int'(sig_digits) > MAX_DIGITS) begin
         length = LEN_W'(MAX_DIGITS);
      end else begin
         length = LEN_W'(sig_digits);
      end
   end

   assign stat.busy  = (state_ff != ST_IDLE);
   assign stat.done  = (state_ff == ST_DONE);
   assign stat.index = idx_ff;

endmodule

// ===== src/wwnr_out_q.sv =====
// ----------------------------------------------------------------------------
// wwnr_out_q: result token queue and output register
// Queues literal and replacement tokens, expands a replacement into digit
// characters one per cycle unless stalled, holds each word until taken.
// ----------------------------------------------------------------------------
module wwnr_out_q import wwnr_pkg::*; #(
   parameter  int MAX_DIGITS = MAX_DIGITS_DEFAULT,
   localparam int LEN_W      = $clog2(MAX_DIGITS + 1),
   localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tok_type          push_tok,
   output logic             full,
   input  logic [3:0]       rep_digits [MAX_DIGITS],
   input  logic [LEN_W-1:0] rep_length,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_byte,
   output logic             out_last
);

   localparam int CNT_W = $clog2(RSP_Q_DEPTH + 1);

   tok_type             q_ff [RSP_Q_DEPTH];
   logic [RSP_Q_AW-1:0] wr_ptr_ff;
   logic [RSP_Q_AW-1:0] rd_ptr_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [IDX_W-1:0]    rep_idx_ff;
   logic                ovalid_ff;
   logic [7:0]          obyte_ff;
   logic                olast_ff;

   tok_type             head;
   logic                have;
   logic                load;
   logic                rep_end;
   logic                pop;
   logic [7:0]          nxt_byte;
   logic                nxt_last;

   // head token and its next output word
   always_comb begin
      head    = q_ff[rd_ptr_ff];
      have    = (cnt_ff != '0);
      load    = !ovalid_ff || out_ready;
      rep_end = ((LEN_W'(rep_idx_ff) + LEN_W'(1)) == rep_length);
      unique case (head.kind)
         TOK_LITERAL: begin
            nxt_byte = head.lit_byte;
            nxt_last = head.last;
         end
         TOK_REPLACE: begin
            nxt_byte = digit_char(rep_digits[rep_idx_ff]);
            nxt_last = head.last && rep_end;
         end
      endcase
      pop = load && have && ((head.kind == TOK_LITERAL) || rep_end);
   end

   assign full = (cnt_ff == CNT_W'(RSP_Q_DEPTH));

   // token storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_tok;
      end
   end

   // pointers, expansion index and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         cnt_ff     <= '0;
         rep_idx_ff <= '0;
         ovalid_ff  <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_Q_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_Q_AW'(1);
         end
         cnt_ff <= cnt_ff + CNT_W'(push) - CNT_W'(pop);
         if (load) begin
            ovalid_ff <= have;
            if (have) begin
               obyte_ff <= nxt_byte;
               olast_ff <= nxt_last;
               if (head.kind == TOK_REPLACE) begin
                  rep_idx_ff <= rep_end ? '0 : (rep_idx_ff + IDX_W'(1));
               end
            end
         end
      end
   end

   assign out_valid = ovalid_ff;
   assign out_byte  = obyte_ff;
   assign out_last  = olast_ff;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: whole_word_number_replacer
// Drives text words into the replacer and checks every rewritten word against
// a cycle-free model of the find and replace. A short table of hand-picked
// texts comes first, then random texts built mostly from the search number's
// digits, separators and letters, across several register settings and
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import wwnr_pkg::*;

   localparam int DIGITS = MAX_DIGITS_DEFAULT;
   localparam int HOLD   = DIGITS + 1;

   typedef struct {
      logic [7:0] b;
      logic       l;
   } text_word_type;

   typedef enum {
      ROW_TEXT,
      ROW_RAW,
      ROW_SEARCH,
      ROW_REPL
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [31:0]  value;
      string        text;
      bit           last;
      bit           typed;
      string        out_text;
   } dir_row_type;

   logic clock;
   logic reset;

   wwnr_req_if req_if ();
   wwnr_rsp_if rsp_if ();
   wwnr_csr_if csr_if ();

   whole_word_number_replacer dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   // model state: configured digit strings and the text being scanned
   logic [3:0] srch_dig [DIGITS];
   int         srch_len;
   logic [3:0] repl_dig [DIGITS];
   int         repl_len;
   logic [7:0] held [HOLD];
   int         held_n;
   logic [7:0] prev_b;
   bit         at_start;

   text_word_type rewritten_q [$];
   text_word_type step_out [$];
   logic [7:0]    text_q [$];

   int mismatch_count;
   int req_gap_pct;
   int rsp_stall_pct;
   bit rsp_hold_req;
   int rsp_hold_left;
   int phase_items;

   logic [7:0] seps [10] = '{8'h20, 8'h2C, 8'h2E, 8'h2D, 8'h2F,
                             8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B};

   dir_row_type dir_rows [12] = '{
      '{ROW_TEXT,   32'd0,          "x",          1'b1, 1'b1, "x"},
      '{ROW_RAW,    32'h0000_00FF,  "",           1'b1, 1'b0, ""},
      '{ROW_TEXT,   32'd0,          "0",          1'b1, 1'b1, "0"},
      '{ROW_SEARCH, 32'hFFFF_FFFF,  "",           1'b0, 1'b0, ""},
      '{ROW_REPL,   32'd0,          "",           1'b0, 1'b0, ""},
      '{ROW_TEXT,   32'd0,          "4294967295", 1'b1, 1'b1, "0"},
      '{ROW_SEARCH, 32'd42,         "",           1'b0, 1'b0, ""},
      '{ROW_REPL,   32'hFFFF_FFFF,  "",           1'b0, 1'b0, ""},
      '{ROW_TEXT,   32'd0,          "a42",        1'b1, 1'b1, "a42"},
      '{ROW_TEXT,   32'd0,          "42",         1'b0, 1'b0, ""},
      '{ROW_RAW,    32'h0000_0080,  "",           1'b1, 1'b0, ""},
      '{ROW_TEXT,   32'd0,          "442",        1'b1, 1'b1, "442"}
   };

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic bit is_alnum(input logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   // decimal digits of a value, most significant first, no leading zeros
   function automatic void to_digits(input logic [31:0] v, output logic [3:0] d [DIGITS],
                                     output int len);
      logic [3:0]      rev [20];
      int              n;
      longint unsigned x;
      x = v;
      n = 0;
      do begin
         rev[n] = 4'(x % 10);
         x = x / 10;
         n++;
      end while (x != 0 && n < 20);
      len = (n > DIGITS) ? DIGITS : n;
      for (int i = 0; i < DIGITS; i++) begin
         if (i < len) d[i] = rev[n - 1 - i];
         else d[i] = 4'd0;
      end
   endfunction

   function automatic void clear_text();
      for (int i = 0; i < HOLD; i++) held[i] = 8'h00;
      held_n   = 0;
      prev_b   = 8'h00;
      at_start = 1'b1;
   endfunction

   function automatic void emit_word(input logic [7:0] b);
      text_word_type w;
      if (step_out.size() < 12) begin
         w.b = b;
         w.l = 1'b0;
         step_out.push_back(w);
      end
   endfunction

   // pass k held bytes on
   function automatic void drop_held(input int k);
      prev_b   = held[k - 1];
      at_start = 1'b0;
      for (int i = 0; i < HOLD; i++) held[i] = (i + k < held_n) ? held[i + k] : 8'h00;
      held_n = held_n - k;
   endfunction

   // one input word: appends the rewritten words it releases to step_out
   function automatic void rewrite_byte(input logic [7:0] b, input logic l);
      int len;
      int lim;
      int m;
      bit left_ok;
      bit trail_ok;
      step_out.delete();
      if (held_n >= HOLD) begin
         emit_word(held[0]);
         drop_held(1);
      end
      held[held_n] = b;
      held_n++;
      while (held_n > 0) begin
         len = srch_len;
         lim = (held_n < len) ? held_n : len;
         m = 0;
         while (m < lim && held[m] == (ASCII_ZERO + {4'd0, srch_dig[m]})) m++;
         if (m == len) begin
            if (held_n == len && !l) break;
            left_ok  = at_start || !is_alnum(prev_b);
            trail_ok = (held_n == len) || !is_alnum(held[len]);
            if (left_ok && trail_ok) begin
               for (int i = 0; i < repl_len; i++) emit_word(ASCII_ZERO + {4'd0, repl_dig[i]});
            end else begin
               for (int i = 0; i < len; i++) emit_word(held[i]);
            end
            drop_held(len);
            continue;
         end
         if (m == held_n && !l) break;
         emit_word(held[0]);
         drop_held(1);
      end
      if (l) begin
         if (step_out.size() > 0) step_out[step_out.size() - 1].l = 1'b1;
         clear_text();
      end
   endfunction

   // ------------------------------------------------------------- drivers

   // offer one text word, with random gaps before it
   task automatic send_byte(input logic [7:0] b, input logic l, input bit typed);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      req_if.in_last <= l;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      rewrite_byte(b, l);
      if (!typed) begin
         foreach (step_out[i]) rewritten_q.push_back(step_out[i]);
      end
      phase_items++;
   endtask

   task automatic req_release();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   // register write once the block has drained
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      req_release();
      while (rewritten_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_if.valid    <= 1'b1;
      csr_if.wr_index <= idx;
      csr_if.wr_data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      if (idx == CSR_SEARCH_NUMBER) to_digits(data, srch_dig, srch_len);
      else to_digits(data, repl_dig, repl_len);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // leading n digits of the search or replacement text into text_q
   function automatic void push_number_text(input bit of_repl, input int n);
      for (int i = 0; i < n; i++)
         text_q.push_back(ASCII_ZERO + {4'd0, of_repl ? repl_dig[i] : srch_dig[i]});
   endfunction

   // random text ending in a last word, built from tokens
   task automatic send_random_text();
      int tokens;
      int pick;
      text_q.delete();
      tokens = $urandom_range(1, 8);
      for (int t = 0; t < tokens; t++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) push_number_text(1'b0, srch_len);
         else if (pick < 45) push_number_text(1'b0, $urandom_range(1, srch_len));
         else if (pick < 60) text_q.push_back(seps[$urandom_range(0, 9)]);
         else if (pick < 65) text_q.push_back(8'($urandom_range(128, 255)));
         else if (pick < 80) begin
            case ($urandom_range(0, 2))
               0: text_q.push_back(8'("a" + $urandom_range(0, 25)));
               1: text_q.push_back(8'("A" + $urandom_range(0, 25)));
               default: text_q.push_back(8'("0" + $urandom_range(0, 9)));
            endcase
         end else if (pick < 90) push_number_text(1'b1, repl_len);
         else text_q.push_back(8'($urandom_range(0, 255)));
      end
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1, 1'b0);
   endtask

   function automatic logic [31:0] rand_number();
      return $urandom >> $urandom_range(0, 31);
   endfunction

   // receiver: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (rsp_hold_req) begin
         rsp_hold_left = 250;
         rsp_hold_req  = 1'b0;
      end
      if (rsp_hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // ------------------------------------------------------------- checker

   always @(posedge clock) begin : check_words
      text_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (rewritten_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: byte %h last %b", rsp_if.out_byte, rsp_if.out_last);
         end else begin
            want = rewritten_q.pop_front();
            if (rsp_if.out_byte !== want.b || rsp_if.out_last !== want.l) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("word mismatch: expected byte %h last %b, got byte %h last %b",
                           want.b, want.l, rsp_if.out_byte, rsp_if.out_last);
            end
         end
      end
   end

   // run limit
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------ stimulus

   initial begin
      text_word_type w;
      logic [31:0] srch_set [6];
      logic [31:0] repl_set [6];

      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.in_byte  = 8'h00;
      req_if.in_last  = 1'b0;
      rsp_if.ready    = 1'b0;
      csr_if.valid    = 1'b0;
      csr_if.wr_index = CSR_SEARCH_NUMBER;
      csr_if.wr_data  = 32'd0;
      mismatch_count  = 0;
      rsp_hold_req    = 1'b0;
      rsp_hold_left   = 0;
      req_gap_pct     = 16;
      rsp_stall_pct   = 50;
      to_digits(32'd0, srch_dig, srch_len);
      to_digits(32'd0, repl_dig, repl_len);
      clear_text();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_rows[r]) begin
         case (dir_rows[r].kind)
            ROW_SEARCH: write_register(CSR_SEARCH_NUMBER, dir_rows[r].value);
            ROW_REPL:   write_register(CSR_REPLACEMENT_NUMBER, dir_rows[r].value);
            ROW_RAW:    send_byte(dir_rows[r].value[7:0], dir_rows[r].last, 1'b0);
            default: begin
               // typed rows start on an empty hold, so their words are known up front
               if (dir_rows[r].typed) begin
                  for (int i = 0; i < dir_rows[r].out_text.len(); i++) begin
                     w.b = dir_rows[r].out_text[i];
                     w.l = dir_rows[r].last && (i == dir_rows[r].out_text.len() - 1);
                     rewritten_q.push_back(w);
                  end
               end
               for (int i = 0; i < dir_rows[r].text.len(); i++)
                  send_byte(dir_rows[r].text[i],
                            dir_rows[r].last && (i == dir_rows[r].text.len() - 1),
                            dir_rows[r].typed);
            end
         endcase
      end

      // a short flush and a rejected run that cannot restart a match
      send_byte("4", 1'b1, 1'b0);
      write_register(CSR_SEARCH_NUMBER, 32'd11);
      send_byte("1", 1'b0, 1'b0);
      send_byte("1", 1'b0, 1'b0);
      send_byte("1", 1'b1, 1'b0);

      // random phases over several settings
      srch_set = '{32'd0, 32'hFFFF_FFFF, rand_number(), 32'($urandom_range(0, 99)),
                   rand_number(), 32'd5};
      repl_set = '{32'hFFFF_FFFF, 32'd7, rand_number(), 32'd0, rand_number(), 32'd123};
      for (int p = 0; p < 6; p++) begin
         write_register(CSR_SEARCH_NUMBER, srch_set[p]);
         write_register(CSR_REPLACEMENT_NUMBER, repl_set[p]);
         case (p / 2)
            0: begin
               req_gap_pct   = 16;
               rsp_stall_pct = 50;
            end
            1: begin
               req_gap_pct   = 50;
               rsp_stall_pct = 16;
            end
            default: begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
         endcase
         // long receiver hold-off so the block backs up into its input
         if (p == 4) rsp_hold_req = 1'b1;
         phase_items = 0;
         while (phase_items < 60) send_random_text();
      end

      // drain
      req_release();
      while (rewritten_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      mismatch_count = mismatch_count + rewritten_q.size();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== whole_word_number_replacer.f =====
src/wwnr_pkg.sv
src/wwnr_intf.sv
src/wwnr_cell.sv
src/wwnr_dec_conv.sv
src/wwnr_out_q.sv
src/whole_word_number_replacer.sv
bench/testbench.sv
